### sv/edal_pkg.sv
// Package for the extent directory allocator: commands, status codes, slot kinds,
// the directory record layout and the sequencer states. No dependencies.
package edal_pkg;

    localparam int DIR_ENTRIES_DEF = 64;
    localparam int NAME_W          = 256;

    localparam logic [2:0] CMD_FORMAT = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_CREATE = 3'd2;
    localparam logic [2:0] CMD_SETSZ  = 3'd3;
    localparam logic [2:0] CMD_DELETE = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_EXISTS   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOSPACE  = 3'd4;
    localparam logic [2:0] ST_OVERRES  = 3'd5;

    localparam logic [1:0] KIND_END  = 2'd0;
    localparam logic [1:0] KIND_DEL  = 2'd1;
    localparam logic [1:0] KIND_LIVE = 2'd2;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [31:0]       start;
        logic [31:0]       reserved;
        logic [63:0]       size;
    } rec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_FIT_RD,
        S_FIT_CHK,
        S_FIT_EVAL,
        S_WRITE,
        S_RESP
    } state_t;

endpackage

### sv/edal_if.sv
// Channel interfaces of the extent directory allocator: request, result and
// configuration write. Depends on nothing.
interface edal_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [63:0] name_w0;
    logic [63:0] name_w1;
    logic [63:0] name_w2;
    logic [63:0] name_w3;
    logic [31:0] size_mib;
    logic [63:0] new_size;
    modport source (output valid, cmd, name_w0, name_w1, name_w2, name_w3, size_mib,
                    new_size, input ready);
    modport sink (input valid, cmd, name_w0, name_w1, name_w2, name_w3, size_mib,
                  new_size, output ready);
endinterface

interface edal_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  entry_index;
    logic [30:0] start_block;
    logic [31:0] reserved_blocks;
    logic [63:0] file_size;
    modport source (output valid, status, entry_index, start_block, reserved_blocks,
                    file_size, input ready);
    modport sink (input valid, status, entry_index, start_block, reserved_blocks,
                  file_size, output ready);
endinterface

interface edal_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### sv/extent_directory_allocator_core.sv
// Top level of the extent directory allocator: sequencer, directory memories
// and result register. Depends on edal_pkg and the interfaces in edal_if.sv.
//
// Usage. Requests arrive on req (format, lookup, create, set size, delete),
// each carrying a 256-bit name, a MiB count for create and a byte size for
// set size. Every request produces exactly one result on rsp. The disk
// capacity in MiB is written through cfg, which is always ready; write it
// only while no request is in flight.
// Operation. One request is worked on at a time; req is ready only while the
// sequencer is idle. A directory scan reads each slot from memory and then
// compares it, and stops at the end mark. Create runs a first-fit pass over
// all used slots once per visited gap. Format and unused commands go straight
// to the response state.
// Reset clears the slot valid bits, so every slot reads as end of directory;
// no clearing pass is needed. The directory records themselves are not reset.
// A finished result sits in the output register. If rsp stalls, one more
// request can still be taken, but its result waits in the response state and
// no further request is taken until the output register is passed on.
module extent_directory_allocator_core
    import edal_pkg::*;
#(
    parameter int DIR_ENTRIES = DIR_ENTRIES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    edal_req_if.sink     req,
    edal_rsp_if.source   rsp,
    edal_cfg_if.sink     cfg
);

    localparam int IW = $clog2(DIR_ENTRIES);
    localparam int CW = $clog2(DIR_ENTRIES + 1);
    localparam logic [CW-1:0] N_C    = CW'(DIR_ENTRIES);
    localparam logic [CW-1:0] LAST_C = CW'(DIR_ENTRIES - 1);

    // Directory memories, one read port and one write port each.
    logic [1:0] kind_mem [DIR_ENTRIES];
    rec_t       rec_mem  [DIR_ENTRIES];
    logic [1:0] rd_kind;
    rec_t       rd_rec;

    state_t state_reg, state_next;

    logic [DIR_ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]  disk_mib_reg;
    logic [2:0]   cmd_reg;
    logic [NAME_W-1:0] name_reg;
    logic [31:0]  req_reg;
    logic [63:0]  new_size_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] slot_reg, slot_next;
    logic         del_have_reg, del_have_next;
    logic [CW-1:0] del_idx_reg, del_idx_next;
    logic         key_have_reg, key_have_next;
    logic [31:0]  key_start_reg, key_start_next;
    logic [CW-1:0] key_idx_reg, key_idx_next;
    logic         pick_have_reg, pick_have_next;
    logic [31:0]  pick_start_reg, pick_start_next;
    logic [31:0]  pick_res_reg, pick_res_next;
    logic [CW-1:0] pick_idx_reg, pick_idx_next;
    logic [34:0]  prev_reg, prev_next;
    logic [2:0]   res_status_reg, res_status_next;
    logic [CW-1:0] res_idx_reg, res_idx_next;
    logic [31:0]  res_start_reg, res_start_next;
    logic [31:0]  res_res_reg, res_res_next;
    logic [63:0]  res_size_reg, res_size_next;
    logic         rsp_valid_reg;
    logic [2:0]   rsp_status_reg;
    logic [5:0]   rsp_idx_reg;
    logic [30:0]  rsp_start_reg;
    logic [31:0]  rsp_res_reg;
    logic [63:0]  rsp_size_reg;

    logic         req_acc;
    logic         rsp_load;
    logic [IW-1:0] rd_addr;
    logic [1:0]   kind_eff;
    logic         is_end, is_del, is_live, name_hit, find_done, over_res;
    logic         fit_after, fit_better;
    logic signed [34:0] last_block, this_start, prev_s, gap;
    logic         fits;
    logic [32:0]  mib_even;
    logic         kind_we, rec_we;
    logic [IW-1:0] wr_addr;
    logic [1:0]   wr_kind;
    rec_t         wr_rec;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_acc   = req.valid && req.ready;
    assign rsp_load  = (state_reg == S_RESP) && (!rsp_valid_reg || rsp.ready);

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.entry_index     = rsp_idx_reg;
    assign rsp.start_block     = rsp_start_reg;
    assign rsp.reserved_blocks = rsp_res_reg;
    assign rsp.file_size       = rsp_size_reg;

    assign rd_addr   = idx_reg[IW-1:0];
    assign kind_eff  = valid_reg[rd_addr] ? rd_kind : KIND_END;
    assign is_end    = (kind_eff == KIND_END);
    assign is_del    = (kind_eff == KIND_DEL);
    assign is_live   = (kind_eff == KIND_LIVE);
    assign name_hit  = is_live && (rd_rec.name == name_reg);
    assign find_done = is_end || (idx_reg == LAST_C);
    assign over_res  = {11'd0, rd_rec.reserved, 21'd0} < new_size_reg;

    // A live slot becomes the candidate if it comes after the last picked extent
    // in (start, slot) order and has a lower start than the current candidate.
    assign fit_after  = !key_have_reg || (rd_rec.start > key_start_reg) ||
                        ((rd_rec.start == key_start_reg) && (idx_reg > key_idx_reg));
    assign fit_better = !pick_have_reg || (rd_rec.start < pick_start_reg);

    // The gap ends at the next extent, or at the last block of the disk.
    assign last_block = $signed({4'd0, disk_mib_reg[31:1]}) - 35'sd1;
    assign this_start = pick_have_reg ? $signed({3'd0, pick_start_reg}) : last_block;
    assign prev_s     = $signed(prev_reg);
    assign gap        = this_start - prev_s;
    assign fits       = (this_start >= prev_s) && (gap >= $signed({3'd0, req_reg}));

    assign mib_even = {1'b0, req.size_mib} + {32'd0, req.size_mib[0]};

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    if (req.cmd == CMD_LOOKUP || req.cmd == CMD_CREATE ||
                        req.cmd == CMD_SETSZ || req.cmd == CMD_DELETE)
                        state_next = S_FIND_RD;
                    else
                        state_next = S_RESP;
                end
            end
            S_FIND_RD:  state_next = S_FIND_CHK;
            S_FIND_CHK:
            begin
                if (name_hit)
                begin
                    if (cmd_reg == CMD_DELETE || (cmd_reg == CMD_SETSZ && !over_res))
                        state_next = S_WRITE;
                    else
                        state_next = S_RESP;
                end
                else if (find_done)
                begin
                    if (cmd_reg == CMD_CREATE && (del_have_reg || is_del || is_end))
                        state_next = S_FIT_RD;
                    else
                        state_next = S_RESP;
                end
                else
                    state_next = S_FIND_RD;
            end
            S_FIT_RD:   state_next = (idx_reg == used_reg) ? S_FIT_EVAL : S_FIT_CHK;
            S_FIT_CHK:  state_next = S_FIT_RD;
            S_FIT_EVAL:
            begin
                if (fits)
                    state_next = S_WRITE;
                else if (!pick_have_reg)
                    state_next = S_RESP;
                else
                    state_next = S_FIT_RD;
            end
            S_WRITE:    state_next = S_RESP;
            S_RESP:     state_next = rsp_load ? S_IDLE : S_RESP;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        slot_next       = slot_reg;
        del_have_next   = del_have_reg;
        del_idx_next    = del_idx_reg;
        key_have_next   = key_have_reg;
        key_start_next  = key_start_reg;
        key_idx_next    = key_idx_reg;
        pick_have_next  = pick_have_reg;
        pick_start_next = pick_start_reg;
        pick_res_next   = pick_res_reg;
        pick_idx_next   = pick_idx_reg;
        prev_next       = prev_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_start_next  = res_start_reg;
        res_res_next    = res_res_reg;
        res_size_next   = res_size_reg;
        kind_we         = 1'b0;
        rec_we          = 1'b0;
        wr_addr         = slot_reg[IW-1:0];
        wr_kind         = KIND_LIVE;
        wr_rec          = rd_rec;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    idx_next        = '0;
                    del_have_next   = 1'b0;
                    res_status_next = ST_NOTFOUND;
                    res_idx_next    = '0;
                    res_start_next  = '0;
                    res_res_next    = '0;
                    res_size_next   = '0;
                    if (req.cmd == CMD_FORMAT)
                    begin
                        valid_next      = '0;
                        res_status_next = ST_OK;
                    end
                end
            end
            S_FIND_CHK:
            begin
                if (name_hit)
                begin
                    res_idx_next   = idx_reg;
                    res_start_next = rd_rec.start;
                    res_res_next   = rd_rec.reserved;
                    res_size_next  = rd_rec.size;
                    slot_next      = idx_reg;
                    if (cmd_reg == CMD_CREATE)
                        res_status_next = ST_EXISTS;
                    else if (cmd_reg == CMD_SETSZ && over_res)
                        res_status_next = ST_OVERRES;
                    else
                        res_status_next = ST_OK;
                    if (cmd_reg == CMD_SETSZ && !over_res)
                        res_size_next = new_size_reg;
                end
                else if (find_done)
                begin
                    used_next = is_end ? idx_reg : N_C;
                    slot_next = del_have_reg ? del_idx_reg : idx_reg;
                    if (cmd_reg == CMD_CREATE)
                        res_status_next = (del_have_reg || is_del || is_end) ? ST_OK : ST_FULL;
                    idx_next       = '0;
                    prev_next      = 35'd1;
                    key_have_next  = 1'b0;
                    pick_have_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (is_del && !del_have_reg)
                    begin
                        del_have_next = 1'b1;
                        del_idx_next  = idx_reg;
                    end
                end
            end
            S_FIT_CHK:
            begin
                if (is_live && fit_after && fit_better)
                begin
                    pick_have_next  = 1'b1;
                    pick_start_next = rd_rec.start;
                    pick_res_next   = rd_rec.reserved;
                    pick_idx_next   = idx_reg;
                end
                idx_next = idx_reg + 1'b1;
            end
            S_FIT_EVAL:
            begin
                if (fits)
                begin
                    res_status_next = ST_OK;
                    res_idx_next    = slot_reg;
                    res_start_next  = prev_reg[31:0];
                    res_res_next    = req_reg;
                    res_size_next   = '0;
                end
                else if (!pick_have_reg)
                    res_status_next = ST_NOSPACE;
                else
                begin
                    prev_next      = {3'd0, pick_start_reg} + {3'd0, pick_res_reg};
                    key_have_next  = 1'b1;
                    key_start_next = pick_start_reg;
                    key_idx_next   = pick_idx_reg;
                    pick_have_next = 1'b0;
                    idx_next       = '0;
                end
            end
            S_WRITE:
            begin
                case (cmd_reg)
                    CMD_CREATE:
                    begin
                        kind_we         = 1'b1;
                        rec_we          = 1'b1;
                        wr_kind         = KIND_LIVE;
                        wr_rec.name     = name_reg;
                        wr_rec.start    = res_start_reg;
                        wr_rec.reserved = req_reg;
                        wr_rec.size     = '0;
                        valid_next[slot_reg[IW-1:0]] = 1'b1;
                        // Appending at the end mark moves the mark one slot on.
                        if (slot_reg == used_reg && (used_reg + 1'b1) < N_C)
                            valid_next[IW'(used_reg + 1'b1)] = 1'b0;
                    end
                    CMD_SETSZ:
                    begin
                        rec_we      = 1'b1;
                        wr_rec.size = new_size_reg;
                    end
                    CMD_DELETE:
                    begin
                        kind_we = 1'b1;
                        wr_kind = KIND_DEL;
                    end
                    default:
                    begin
                        kind_we = 1'b0;
                    end
                endcase
            end
            default:
            begin
                kind_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIND_RD || state_reg == S_FIT_RD)
        begin
            rd_kind <= kind_mem[rd_addr];
            rd_rec  <= rec_mem[rd_addr];
        end
        if (kind_we)
            kind_mem[wr_addr] <= wr_kind;
        if (rec_we)
            rec_mem[wr_addr] <= wr_rec;
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            cmd_reg      <= req.cmd;
            name_reg     <= {req.name_w3, req.name_w2, req.name_w1, req.name_w0};
            req_reg      <= mib_even[32:1];
            new_size_reg <= req.new_size;
        end
        idx_reg        <= idx_next;
        used_reg       <= used_next;
        slot_reg       <= slot_next;
        del_idx_reg    <= del_idx_next;
        key_start_reg  <= key_start_next;
        key_idx_reg    <= key_idx_next;
        pick_start_reg <= pick_start_next;
        pick_res_reg   <= pick_res_next;
        pick_idx_reg   <= pick_idx_next;
        prev_reg       <= prev_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_start_reg  <= res_start_next;
        res_res_reg    <= res_res_next;
        res_size_reg   <= res_size_next;
        if (rsp_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_idx_reg    <= 6'(res_idx_reg);
            rsp_start_reg  <= res_start_reg[30:0];
            rsp_res_reg    <= res_res_reg;
            rsp_size_reg   <= res_size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            disk_mib_reg  <= '0;
            del_have_reg  <= 1'b0;
            key_have_reg  <= 1'b0;
            pick_have_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            del_have_reg  <= del_have_next;
            key_have_reg  <= key_have_next;
            pick_have_reg <= pick_have_next;
            if (cfg.valid && cfg.ready)
                disk_mib_reg <= cfg.data;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    a_format_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && req.cmd == CMD_FORMAT) |=> (valid_reg == '0))
        else $error("format did not clear the directory");

    a_fit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIT_CHK) |-> (idx_reg < used_reg))
        else $error("fit scan ran past the used slots");

    a_create_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && cmd_reg == CMD_CREATE) |->
        (slot_reg <= used_reg && slot_reg < N_C))
        else $error("create writes outside the directory");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> (state_reg != S_IDLE))
        else $error("request accepted without work");

endmodule
